>>> design/rgmd_pkg.sv
package rgmd_pkg;

   localparam int MAX_SIDE   = 256;
   localparam int IMAGE_SIZE = 4096;

   localparam int DIV_STEPS  = 48;
   localparam int SQRT_STEPS = 24;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_EMPTY  = 2'd1;
   localparam logic [1:0] STATUS_SINGLE = 2'd2;

   localparam logic [2:0] CSR_CENTER_X  = 3'd0;
   localparam logic [2:0] CSR_CENTER_Y  = 3'd1;
   localparam logic [2:0] CSR_RECT_SIZE = 3'd2;
   localparam logic [2:0] CSR_GAP       = 3'd3;
   localparam logic [2:0] CSR_QUADRANT  = 3'd4;
   localparam logic [2:0] CSR_REF_GREEN = 3'd5;

   typedef struct packed {
      logic div_load_mean;
      logic div_load_sd;
      logic div_step;
      logic sqrt_init;
      logic sqrt_step;
      logic latch_mean;
      logic load_out;
   } rgmd_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic count_one;
      logic out_free;
   } rgmd_stat_type;

endpackage

>>> design/rgmd_ctrl.sv
module rgmd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tlast,
   output logic                   req_tready,
   input  rgmd_pkg::rgmd_stat_type stat,
   output rgmd_pkg::rgmd_cmd_type  cmd
);
   import rgmd_pkg::*;

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_DRAIN     = 3'd1;
   localparam logic [2:0] ST_DECIDE    = 3'd2;
   localparam logic [2:0] ST_DIV_MEAN  = 3'd3;
   localparam logic [2:0] ST_POST_MEAN = 3'd4;
   localparam logic [2:0] ST_DIV_SD    = 3'd5;
   localparam logic [2:0] ST_SQRT      = 3'd6;
   localparam logic [2:0] ST_FINISH    = 3'd7;

   localparam logic [5:0] DivLast  = 6'(DIV_STEPS - 1);
   localparam logic [5:0] SqrtLast = 6'(SQRT_STEPS - 1);

   logic [2:0] state_ff, state_in;
   logic [5:0] step_ff, step_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff + 6'd1;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tlast) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            step_in = '0;
            if (stat.count_zero) begin
               state_in = ST_FINISH;
            end else begin
               cmd.div_load_mean = 1'b1;
               state_in          = ST_DIV_MEAN;
            end
         end
         ST_DIV_MEAN: begin
            cmd.div_step = 1'b1;
            if (step_ff == DivLast) begin
               state_in = ST_POST_MEAN;
            end
         end
         ST_POST_MEAN: begin
            cmd.latch_mean = 1'b1;
            step_in        = '0;
            if (stat.count_one) begin
               state_in = ST_FINISH;
            end else begin
               cmd.div_load_sd = 1'b1;
               state_in        = ST_DIV_SD;
            end
         end
         ST_DIV_SD: begin
            cmd.div_step = 1'b1;
            if (step_ff == DivLast) begin
               cmd.sqrt_init = 1'b1;
               step_in       = '0;
               state_in      = ST_SQRT;
            end
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (step_ff == SqrtLast) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   a_frame_end_drains: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> (state_ff == ST_DRAIN))
      else $error("frame end not followed by drain");

   a_div_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_MEAN || state_ff == ST_DIV_SD) |-> (step_ff <= DivLast))
      else $error("divider step count overrun");

   a_sqrt_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQRT) |-> (step_ff <= SqrtLast))
      else $error("root step count overrun");

endmodule

>>> design/rgmd_dp.sv
module rgmd_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [2:0]              csr_addr,
   input  logic [11:0]             csr_wdata,
   input  logic                    req_tvalid,
   input  logic                    req_tready,
   input  logic [11:0]             pixel_row,
   input  logic [11:0]             pixel_col,
   input  logic [7:0]              green,
   input  rgmd_pkg::rgmd_cmd_type  cmd,
   output rgmd_pkg::rgmd_stat_type stat,
   input  logic                    rsp_tready,
   output logic                    rsp_tvalid,
   output logic [15:0]             mean_green,
   output logic [15:0]             std_dev,
   output logic [16:0]             pixel_total,
   output logic [1:0]              status
);
   import rgmd_pkg::*;

   localparam logic [1:0]  QUAD_UL = 2'd0;
   localparam logic [1:0]  QUAD_UR = 2'd1;
   localparam logic [1:0]  QUAD_LL = 2'd3;
   localparam logic [12:0] MaxSide = 13'(MAX_SIDE);
   localparam logic [17:0] ImgSize = 18'(IMAGE_SIZE);

   logic [11:0] center_x_ff, center_y_ff, gap_ff, ref_green_ff;
   logic [8:0]  rect_size_ff;
   logic [1:0]  quadrant_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff  <= '0;
         center_y_ff  <= '0;
         rect_size_ff <= 9'd16;
         gap_ff       <= '0;
         quadrant_ff  <= '0;
         ref_green_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_CENTER_X:  center_x_ff  <= csr_wdata;
            CSR_CENTER_Y:  center_y_ff  <= csr_wdata;
            CSR_RECT_SIZE: rect_size_ff <= csr_wdata[8:0];
            CSR_GAP:       gap_ff       <= csr_wdata;
            CSR_QUADRANT:  quadrant_ff  <= csr_wdata[1:0];
            CSR_REF_GREEN: ref_green_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // region test
   logic [12:0]        side_w;
   logic signed [15:0] side_s, gap_s, cx_s, cy_s, row_s, col_s, r0, c0;
   logic               in_image, roi_hit, accept;

   always_comb begin
      side_w = (13'(rect_size_ff) > MaxSide) ? MaxSide : 13'(rect_size_ff);
      side_s = signed'({3'b000, side_w});
      gap_s  = signed'({4'b0000, gap_ff});
      cx_s   = signed'({4'b0000, center_x_ff});
      cy_s   = signed'({4'b0000, center_y_ff});
      row_s  = signed'({4'b0000, pixel_row});
      col_s  = signed'({4'b0000, pixel_col});
      r0 = (quadrant_ff == QUAD_UL || quadrant_ff == QUAD_UR) ? (cy_s - side_s - gap_s)
                                                                : (cy_s + gap_s);
      c0 = (quadrant_ff == QUAD_UL || quadrant_ff == QUAD_LL) ? (cx_s - side_s - gap_s)
                                                                : (cx_s + gap_s);
      in_image = ({6'b0, pixel_row} < ImgSize) && ({6'b0, pixel_col} < ImgSize);
      roi_hit  = in_image && (row_s >= r0) && (row_s < r0 + side_s)
                 && (col_s >= c0) && (col_s < c0 + side_s);
   end

   assign accept = req_tvalid && req_tready;

   // first stage: square of deviation
   logic [11:0] g16, diff;
   logic        p_add_ff;
   logic [7:0]  p_green_ff;
   logic [23:0] p_sq_ff;

   always_comb begin
      g16  = {green, 4'b0000};
      diff = (g16 >= ref_green_ff) ? (g16 - ref_green_ff) : (ref_green_ff - g16);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_add_ff <= 1'b0;
      end else begin
         p_add_ff <= accept && roi_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p_green_ff <= green;
         p_sq_ff    <= diff * diff;
      end
   end

   // second stage: saturating accumulators
   logic [16:0] count_ff, count_in;
   logic [23:0] sum_ff, sum_in;
   logic [39:0] sq_ff, sq_in;
   logic [17:0] count_w;
   logic [24:0] sum_w;
   logic [40:0] sq_w;

   always_comb begin
      count_w  = {1'b0, count_ff} + 18'd1;
      sum_w    = {1'b0, sum_ff} + 25'(p_green_ff);
      sq_w     = {1'b0, sq_ff} + 41'(p_sq_ff);
      count_in = count_ff;
      sum_in   = sum_ff;
      sq_in    = sq_ff;
      if (cmd.load_out) begin
         count_in = '0;
         sum_in   = '0;
         sq_in    = '0;
      end else if (p_add_ff) begin
         count_in = count_w[17] ? '1 : count_w[16:0];
         sum_in   = sum_w[24] ? '1 : sum_w[23:0];
         sq_in    = sq_w[40] ? '1 : sq_w[39:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         sq_ff    <= '0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         sq_ff    <= sq_in;
      end
   end

   // restoring divider, one quotient bit per cycle; quotient register doubles as root operand
   logic [16:0] div_rem_ff, div_rem_in, div_den_ff, div_den_in;
   logic [47:0] div_quo_ff, div_quo_in;
   logic [17:0] div_sh, div_sub;
   logic        div_ge;
   logic [25:0] sq_rem_ff, sq_rem_in;
   logic [23:0] root_ff, root_in;
   logic [27:0] sq_sh, sq_trial, sq_sub;
   logic        sq_ge;

   always_comb begin
      div_sh   = {div_rem_ff, div_quo_ff[47]};
      div_sub  = div_sh - {1'b0, div_den_ff};
      div_ge   = (div_sh >= {1'b0, div_den_ff});
      sq_sh    = {sq_rem_ff, div_quo_ff[47:46]};
      sq_trial = {2'b00, root_ff, 2'b01};
      sq_sub   = sq_sh - sq_trial;
      sq_ge    = (sq_sh >= sq_trial);

      div_rem_in = div_rem_ff;
      div_den_in = div_den_ff;
      div_quo_in = div_quo_ff;
      sq_rem_in  = sq_rem_ff;
      root_in    = root_ff;

      if (cmd.div_load_mean) begin
         div_rem_in = '0;
         div_den_in = count_ff;
         div_quo_in = 48'({sum_ff, 8'h00}) + 48'(count_ff[16:1]);
      end else if (cmd.div_load_sd) begin
         div_rem_in = '0;
         div_den_in = count_ff - 17'd1;
         div_quo_in = {sq_ff, 8'h00};
      end else if (cmd.div_step) begin
         div_rem_in = div_ge ? div_sub[16:0] : div_sh[16:0];
         div_quo_in = {div_quo_ff[46:0], div_ge};
      end else if (cmd.sqrt_step) begin
         div_quo_in = {div_quo_ff[45:0], 2'b00};
      end

      if (cmd.sqrt_init) begin
         sq_rem_in = '0;
         root_in   = '0;
      end else if (cmd.sqrt_step) begin
         sq_rem_in = sq_ge ? sq_sub[25:0] : sq_sh[25:0];
         root_in   = {root_ff[22:0], sq_ge};
      end
   end

   always_ff @(posedge clock) begin
      div_rem_ff <= div_rem_in;
      div_den_ff <= div_den_in;
      div_quo_ff <= div_quo_in;
      sq_rem_ff  <= sq_rem_in;
      root_ff    <= root_in;
   end

   logic [15:0] mean_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch_mean) begin
         mean_ff <= (|div_quo_ff[47:16]) ? 16'hFFFF : div_quo_ff[15:0];
      end
   end

   // result register
   logic        rsp_valid_ff;
   logic [15:0] rsp_mean_ff, rsp_sd_ff;
   logic [16:0] rsp_total_ff;
   logic [1:0]  rsp_status_ff, status_w;

   always_comb begin
      if (count_ff == 17'd0) begin
         status_w = STATUS_EMPTY;
      end else if (count_ff == 17'd1) begin
         status_w = STATUS_SINGLE;
      end else begin
         status_w = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_status_ff <= status_w;
         rsp_total_ff  <= count_ff;
         rsp_mean_ff   <= (status_w == STATUS_EMPTY) ? 16'h0000 : mean_ff;
         if (status_w == STATUS_OK) begin
            rsp_sd_ff <= (|root_ff[23:16]) ? 16'hFFFF : root_ff[15:0];
         end else begin
            rsp_sd_ff <= 16'h0000;
         end
      end
   end

   assign stat.count_zero = (count_ff == 17'd0);
   assign stat.count_one  = (count_ff == 17'd1);
   assign stat.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid  = rsp_valid_ff;
   assign mean_green  = rsp_mean_ff;
   assign std_dev     = rsp_sd_ff;
   assign pixel_total = rsp_total_ff;
   assign status      = rsp_status_ff;

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten");

   a_clear_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> (count_ff == 17'd0 && rsp_valid_ff))
      else $error("accumulators not cleared on transfer");

   a_empty_consistent: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 17'd0) |-> (sum_ff == 24'd0 && sq_ff == 40'd0))
      else $error("accumulators disagree on empty region");

endmodule

>>> design/roi_green_mean_and_deviation.sv
// Pixels: one transfer per cycle while idle; each pixel inside the region is registered in
// the first stage, then added to the saturating sums. Frame end: after drain and decide, an
// empty region goes straight to finish, a single pixel runs the mean divide, otherwise the
// mean divide, deviation divide and square root run; finish waits on a stalled receiver.
// No pixel is taken from frame end until the result is in the output register.
// Synchronous active-high reset: registers to their defaults (rect_size 16), sums cleared.
module roi_green_mean_and_deviation (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [11:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // pixel_row[11:0], pixel_col[23:12], green[31:24]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // mean_green[15:0], std_dev[31:16], pixel_total[48:32]
   output logic [1:0]  rsp_tuser    // status[1:0]
);
   import rgmd_pkg::*;

   rgmd_cmd_type  cmd;
   rgmd_stat_type stat;
   logic [15:0]   mean_green, std_dev;
   logic [16:0]   pixel_total;

   rgmd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rgmd_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .pixel_row   (req_tdata[11:0]),
      .pixel_col   (req_tdata[23:12]),
      .green       (req_tdata[31:24]),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .mean_green  (mean_green),
      .std_dev     (std_dev),
      .pixel_total (pixel_total),
      .status      (rsp_tuser)
   );

   assign rsp_tdata = {7'b0000000, pixel_total, std_dev, mean_green};

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import rgmd_pkg::*;

   localparam longint unsigned COUNT_LIMIT = 64'h1_FFFF;
   localparam longint unsigned SUM_LIMIT   = 64'hFF_FFFF;
   localparam longint unsigned SQ_LIMIT    = 64'hFF_FFFF_FFFF;
   localparam int              LONG_PIXELS = 40;

   typedef enum logic [1:0] {
      QUAD_UPPER_LEFT  = 2'd0,
      QUAD_UPPER_RIGHT = 2'd1,
      QUAD_LOWER_RIGHT = 2'd2,
      QUAD_LOWER_LEFT  = 2'd3
   } roi_quadrant_type;

   typedef struct packed {
      logic [11:0] row;
      logic [11:0] col;
      logic [7:0]  green;
      logic        frame_end;
   } pixel_item_type;

   typedef struct packed {
      logic [15:0] mean_green;
      logic [15:0] std_dev;
      logic [16:0] pixel_total;
      logic [1:0]  status;
   } roi_stats_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = '0;
   logic [11:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // pixel_row[11:0], pixel_col[23:12], green[31:24]
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;        // mean_green[15:0], std_dev[31:16], pixel_total[48:32]
   logic [1:0]  rsp_tuser;        // status[1:0]

   roi_green_mean_and_deviation dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the register file
   logic [11:0]      cfg_center_x = '0;
   logic [11:0]      cfg_center_y = '0;
   logic [8:0]       cfg_rect_size = 9'd16;
   logic [11:0]      cfg_region_gap = '0;
   roi_quadrant_type cfg_quadrant = QUAD_UPPER_LEFT;
   logic [11:0]      cfg_ref_green = '0;

   longint unsigned acc_count = 0;
   longint unsigned acc_sum = 0;
   longint unsigned acc_sq_dev = 0;

   pixel_item_type pixel_queue[$];
   roi_stats_type  stats_expected[$];
   int             mismatch_count = 0;
   bit             pixel_taken = 1'b0;
   bit             quick_feed = 1'b0;
   int             gap_left = 0;
   int             burst_left = 1;
   int             stall_left = 0;
   int             stall_mode = 0;
   logic [15:0]    stall_bits = '1;

   function automatic void roi_bounds(output int side, output int r0, output int c0);
      side = (cfg_rect_size > MAX_SIDE) ? MAX_SIDE : int'(cfg_rect_size);
      if (cfg_quadrant == QUAD_UPPER_LEFT || cfg_quadrant == QUAD_UPPER_RIGHT)
         r0 = int'(cfg_center_y) - side - int'(cfg_region_gap);
      else
         r0 = int'(cfg_center_y) + int'(cfg_region_gap);
      if (cfg_quadrant == QUAD_UPPER_LEFT || cfg_quadrant == QUAD_LOWER_LEFT)
         c0 = int'(cfg_center_x) - side - int'(cfg_region_gap);
      else
         c0 = int'(cfg_center_x) + int'(cfg_region_gap);
   endfunction

   function automatic bit in_roi(logic [11:0] row, logic [11:0] col);
      int side, r0, c0;
      roi_bounds(side, r0, c0);
      if (int'(row) >= IMAGE_SIZE || int'(col) >= IMAGE_SIZE) return 1'b0;
      return int'(row) >= r0 && int'(row) < r0 + side &&
             int'(col) >= c0 && int'(col) < c0 + side;
   endfunction

   function automatic longint unsigned sat_add(longint unsigned a, longint unsigned b,
                                               longint unsigned limit);
      return (a + b > limit) ? limit : a + b;
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned root = 0;
      longint unsigned trial;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= v) root = trial;
      end
      return root;
   endfunction

   task automatic accumulate_pixel(logic [11:0] row, logic [11:0] col, logic [7:0] green,
                                   logic last);
      longint unsigned g16, diff, mean, dev, quot;
      roi_stats_type stats;
      if (in_roi(row, col)) begin
         g16 = longint'(green) << 4;
         diff = (g16 >= cfg_ref_green) ? g16 - cfg_ref_green : cfg_ref_green - g16;
         acc_count = sat_add(acc_count, 1, COUNT_LIMIT);
         acc_sum = sat_add(acc_sum, green, SUM_LIMIT);
         acc_sq_dev = sat_add(acc_sq_dev, diff * diff, SQ_LIMIT);
      end
      if (last) begin
         mean = 0;
         dev = 0;
         stats.status = STATUS_OK;
         if (acc_count == 0) begin
            stats.status = STATUS_EMPTY;
         end else begin
            mean = (acc_sum * 256 + acc_count / 2) / acc_count;
            if (mean > 65535) mean = 65535;
            if (acc_count == 1) begin
               stats.status = STATUS_SINGLE;
            end else begin
               quot = (acc_sq_dev * 256) / (acc_count - 1);
               dev = floor_sqrt(quot);
               if (dev > 65535) dev = 65535;
            end
         end
         stats.mean_green = mean[15:0];
         stats.std_dev = dev[15:0];
         stats.pixel_total = acc_count[16:0];
         stats_expected.push_back(stats);
         acc_count = 0;
         acc_sum = 0;
         acc_sq_dev = 0;
      end
   endtask

   task automatic check_field(string label, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", label, want, got);
         mismatch_count++;
      end
   endtask

   function automatic int pick_gap();
      if (quick_feed) return 0;
      case ($urandom_range(0, 9))
         0, 1:    return $urandom_range(20, 140);
         2, 3, 4: return 0;
         default: return $urandom_range(1, 5);
      endcase
   endfunction

   always @(negedge clock) begin : drive_pixels
      pixel_item_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || pixel_taken) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (pixel_queue.size() != 0) begin
            item = pixel_queue.pop_front();
            req_tdata <= {item.green, item.col, item.row};
            req_tlast <= item.frame_end;
            req_tvalid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left <= pick_gap();
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_left <= $urandom_range(16, 200);
         stall_mode <= $urandom_range(0, 3);
         stall_bits <= $urandom;
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= stall_bits[stall_left % 16];
         2:       rsp_tready <= ($urandom_range(0, 3) != 0);
         default: rsp_tready <= (stall_left < 4);
      endcase
   end

   always @(posedge clock) begin : watch_transfers
      roi_stats_type want;
      if (reset) begin
         pixel_taken <= 1'b0;
      end else begin
         pixel_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready)
            accumulate_pixel(req_tdata[11:0], req_tdata[23:12], req_tdata[31:24], req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (stats_expected.size() == 0) begin
               $error("result transfer with none pending: mean_green %0d pixel_total %0d",
                      rsp_tdata[15:0], rsp_tdata[48:32]);
               mismatch_count++;
            end else begin
               want = stats_expected.pop_front();
               check_field("mean_green", want.mean_green, rsp_tdata[15:0]);
               check_field("std_dev", want.std_dev, rsp_tdata[31:16]);
               check_field("pixel_total", want.pixel_total, rsp_tdata[48:32]);
               check_field("status", want.status, rsp_tuser);
            end
         end
      end
   end

   task automatic wait_idle();
      do @(posedge clock);
      while (pixel_queue.size() != 0 || req_tvalid || stats_expected.size() != 0);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] index, logic [11:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= index;
      csr_wdata <= value;
   endtask

   task automatic apply_config(logic [11:0] cx, logic [11:0] cy, logic [8:0] side,
                               logic [11:0] gap, roi_quadrant_type quad, logic [11:0] ref_g);
      wait_idle();
      write_reg(CSR_CENTER_X, cx);
      write_reg(CSR_CENTER_Y, cy);
      write_reg(CSR_RECT_SIZE, {3'b000, side});
      write_reg(CSR_GAP, gap);
      write_reg(CSR_QUADRANT, {10'd0, quad});
      write_reg(CSR_REF_GREEN, ref_g);
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_center_x = cx;
      cfg_center_y = cy;
      cfg_rect_size = side;
      cfg_region_gap = gap;
      cfg_quadrant = quad;
      cfg_ref_green = ref_g;
   endtask

   function automatic pixel_item_type make_pixel(logic [11:0] row, logic [11:0] col,
                                                 logic [7:0] green, logic last);
      pixel_item_type p;
      p.row = row;
      p.col = col;
      p.green = green;
      p.frame_end = last;
      return p;
   endfunction

   // mostly inside the region, some on its border, the rest anywhere
   function automatic pixel_item_type roi_pixel(logic last);
      pixel_item_type p;
      int side, r0, c0, rlo, rhi, clo, chi, e;
      int pick;
      roi_bounds(side, r0, c0);
      rlo = (r0 < 0) ? 0 : r0;
      rhi = (r0 + side - 1 > 4095) ? 4095 : r0 + side - 1;
      clo = (c0 < 0) ? 0 : c0;
      chi = (c0 + side - 1 > 4095) ? 4095 : c0 + side - 1;
      pick = $urandom_range(0, 99);
      if (pick < 70 && rlo <= rhi && clo <= chi) begin
         p.row = 12'($urandom_range(rhi, rlo));
         p.col = 12'($urandom_range(chi, clo));
      end else if (pick < 88) begin
         case ($urandom_range(0, 3))
            0:       e = r0 - 1;
            1:       e = r0;
            2:       e = r0 + side - 1;
            default: e = r0 + side;
         endcase
         p.row = e[11:0];
         case ($urandom_range(0, 3))
            0:       e = c0 - 1;
            1:       e = c0;
            2:       e = c0 + side - 1;
            default: e = c0 + side;
         endcase
         p.col = e[11:0];
      end else begin
         p.row = 12'($urandom);
         p.col = 12'($urandom);
      end
      case ($urandom_range(0, 9))
         0:       p.green = 8'h00;
         1:       p.green = 8'hFF;
         default: p.green = 8'($urandom);
      endcase
      p.frame_end = last;
      return p;
   endfunction

   function automatic logic [11:0] pick_coord();
      case ($urandom_range(0, 5))
         0:       return 12'h000;
         1:       return 12'hFFF;
         default: return 12'($urandom);
      endcase
   endfunction

   function automatic logic [8:0] pick_side();
      case ($urandom_range(0, 7))
         0:       return 9'd0;
         1:       return 9'd1;
         2:       return 9'd256;
         3:       return 9'($urandom_range(257, 511));
         4:       return 9'($urandom_range(17, 255));
         default: return 9'($urandom_range(2, 16));
      endcase
   endfunction

   function automatic logic [11:0] pick_gap_reg();
      case ($urandom_range(0, 5))
         0:       return 12'd0;
         1:       return 12'hFFF;
         2:       return 12'($urandom);
         default: return 12'($urandom_range(1, 30));
      endcase
   endfunction

   initial begin : stimulus
      logic [11:0] corner_row[4];
      logic [11:0] corner_col[4];
      int placed, len;
      corner_row = '{12'd1999, 12'd1999, 12'd2000, 12'd2000};
      corner_col = '{12'd1999, 12'd2000, 12'd2000, 12'd1999};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings put the region above the image: always empty
      pixel_queue.push_back(make_pixel(12'hFFF, 12'hFFF, 8'h00, 1'b0));
      pixel_queue.push_back(make_pixel(12'h000, 12'h000, 8'hFF, 1'b1));

      // region rows 203..206, cols 103..106
      apply_config(12'd100, 12'd200, 9'd4, 12'd3, QUAD_LOWER_RIGHT, 12'hFFF);
      pixel_queue.push_back(make_pixel(12'd203, 12'd103, 8'h00, 1'b0));
      pixel_queue.push_back(make_pixel(12'd206, 12'd106, 8'h00, 1'b1));
      pixel_queue.push_back(make_pixel(12'd204, 12'd104, 8'hFF, 1'b1));
      pixel_queue.push_back(make_pixel(12'd207, 12'd103, 8'h07, 1'b0));
      pixel_queue.push_back(make_pixel(12'd205, 12'd102, 8'h80, 1'b1));

      for (int q = 0; q < 4; q++) begin
         apply_config(12'd2000, 12'd2000, 9'd1, 12'd0, roi_quadrant_type'(q), 12'd0);
         pixel_queue.push_back(make_pixel(corner_row[q], corner_col[q], 8'hC8, 1'b0));
         pixel_queue.push_back(make_pixel(corner_row[q], corner_col[q], 8'h11, 1'b1));
      end

      // oversized side, widest gap: only the last pixel of the image is reachable
      apply_config(12'h000, 12'h000, 9'd511, 12'hFFF, QUAD_LOWER_RIGHT, 12'd2048);
      pixel_queue.push_back(make_pixel(12'hFFF, 12'hFFF, 8'hFF, 1'b1));

      apply_config(12'd100, 12'd100, 9'd0, 12'd0, QUAD_LOWER_RIGHT, 12'd100);
      pixel_queue.push_back(make_pixel(12'd100, 12'd100, 8'h42, 1'b1));

      for (int ph = 0; ph < 12; ph++) begin
         apply_config(pick_coord(), pick_coord(), pick_side(), pick_gap_reg(),
                      roi_quadrant_type'($urandom_range(0, 3)), pick_coord());
         placed = 0;
         while (placed < 92) begin
            case ($urandom_range(0, 9))
               0:       len = 1;
               1:       len = 2;
               default: len = $urandom_range(3, 24);
            endcase
            for (int i = 0; i < len; i++)
               pixel_queue.push_back(roi_pixel(i == len - 1));
            placed += len;
         end
      end

      // one long frame fed back to back on a single pixel
      apply_config(12'd1000, 12'd1000, 9'd16, 12'd0, QUAD_LOWER_RIGHT, 12'd0);
      quick_feed = 1'b1;
      for (int i = 0; i < LONG_PIXELS; i++)
         pixel_queue.push_back(make_pixel(12'd1000, 12'd1000, 8'hFF, i == LONG_PIXELS - 1));

      wait_idle();
      repeat (150) @(posedge clock);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

>>> sim.f
design/rgmd_pkg.sv
design/rgmd_ctrl.sv
design/rgmd_dp.sv
design/roi_green_mean_and_deviation.sv
dv/tb_top.sv
